// ===== src/lsir_pkg.sv =====
// shared types and constants for the lattice sir contact update block
package lsir_pkg;

  localparam int COORD_W = 6;
  localparam int DRAW_W  = 16;
  localparam int CNT_OUT_W = 13;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [1:0]           dir_t;
  typedef logic [DRAW_W-1:0]    draw_t;
  typedef logic [1:0]           event_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;
  typedef logic [1:0]           cell_t;

  localparam cell_t CELL_SUSCEPTIBLE = 2'd0;
  localparam cell_t CELL_INFECTED    = 2'd1;
  localparam cell_t CELL_RECOVERED   = 2'd2;

  localparam event_t EVENT_NONE    = 2'd0;
  localparam event_t EVENT_INFECT  = 2'd1;
  localparam event_t EVENT_RECOVER = 2'd2;

  localparam dir_t DIR_ROW_INC = 2'd0;
  localparam dir_t DIR_ROW_DEC = 2'd1;
  localparam dir_t DIR_COL_INC = 2'd2;
  localparam dir_t DIR_COL_DEC = 2'd3;

  localparam draw_t THRESHOLD_RESET = 16'd6586;

  // outcome of one contact attempt, handed from the decision logic to the datapath
  typedef struct packed {
    logic   wr_en;
    logic   wr_active;
    cell_t  wr_cell;
    event_t evt;
    logic   cnt_inc;
    logic   cnt_dec;
  } decision_t;

endpackage

// ===== src/lattice_sir_contact_update.sv =====
// lattice sir contact update: beats pass the attempt stage, then the result registers
// throughput one attempt per cycle while out_ready holds, set by the lattice memory
// (two reads, one write per cycle) with a one-deep forward of the write that lands as
// the next reads issue. reset: synchronous; a clearing pass writes all SIDE*SIDE cells
// (4096 by default) susceptible, the centre infected; in_ready stays low meanwhile
module lattice_sir_contact_update #(
  parameter int SIDE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  lsir_pkg::draw_t    cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsir_pkg::coord_t   site_row,
  input  lsir_pkg::coord_t   site_col,
  input  lsir_pkg::dir_t     direction,
  input  lsir_pkg::draw_t    action_draw,
  output logic               out_valid,
  input  logic               out_ready,
  output lsir_pkg::event_t   event_res,
  output lsir_pkg::cnt_out_t infected_count
);
  import lsir_pkg::*;

  localparam int DEPTH  = SIDE * SIDE;
  localparam int CW     = $clog2(SIDE);
  localparam int AW     = $clog2(DEPTH);
  localparam int NW     = $clog2(DEPTH + 1);
  localparam int EW     = CW + COORD_W;
  localparam int CENTER = (SIDE / 2) * SIDE + (SIDE / 2);

  cell_t lattice [DEPTH];

  draw_t           threshold;
  logic            clearing;
  logic [AW-1:0]   clr_addr;
  logic [NW-1:0]   count;
  logic [NW-1:0]   count_next;

  // input side
  logic [EW-1:0]   row_ext, col_ext;
  logic [CW-1:0]   row_c, col_c, nrow, ncol;
  logic            in_range;
  logic [AW-1:0]   addr_a, addr_p;
  logic            accept;

  // attempt stage
  logic            v2;
  logic            range2;
  logic            above2;
  logic [AW-1:0]   addr_a2, addr_p2;
  cell_t           rd_a2, rd_p2;
  logic            fwd_a2, fwd_p2;
  cell_t           fwd_cell2;
  cell_t           cell_a, cell_p;
  logic            s2_adv;
  decision_t       dec;

  // memory write port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  cell_t           mem_wdata;

  logic [NW+CNT_OUT_W-1:0] cnt_ext;

  always_comb begin
    row_ext  = {{CW{1'b0}}, site_row};
    col_ext  = {{CW{1'b0}}, site_col};
    in_range = (row_ext < EW'(SIDE)) && (col_ext < EW'(SIDE));
    row_c    = row_ext[CW-1:0];
    col_c    = col_ext[CW-1:0];
    nrow     = row_c;
    ncol     = col_c;
    unique case (direction)
      DIR_ROW_INC: nrow = (row_c == CW'(SIDE - 1)) ? '0 : row_c + 1'b1;
      DIR_ROW_DEC: nrow = (row_c == '0) ? CW'(SIDE - 1) : row_c - 1'b1;
      DIR_COL_INC: ncol = (col_c == CW'(SIDE - 1)) ? '0 : col_c + 1'b1;
      DIR_COL_DEC: ncol = (col_c == '0) ? CW'(SIDE - 1) : col_c - 1'b1;
      default: ;
    endcase
    // out-of-range sites read a harmless address
    if (in_range) begin
      addr_a = AW'(row_c) * AW'(SIDE) + AW'(col_c);
      addr_p = AW'(nrow) * AW'(SIDE) + AW'(ncol);
    end else begin
      addr_a = '0;
      addr_p = '0;
    end
  end

  assign s2_adv   = v2 && (!out_valid || out_ready);
  assign in_ready = !clearing && (!v2 || s2_adv);
  assign accept   = in_valid && in_ready;

  // a write landing on the same edge as the read is picked up from the forward copy
  assign cell_a = fwd_a2 ? fwd_cell2 : rd_a2;
  assign cell_p = fwd_p2 ? fwd_cell2 : rd_p2;

  lsir_step u_step (
    .cell_active  (cell_a),
    .cell_passive (cell_p),
    .in_range     (range2),
    .draw_above   (above2),
    .count_zero   (count == '0),
    .dec          (dec)
  );

  always_comb begin
    count_next = count;
    if (dec.cnt_inc) begin
      count_next = count + 1'b1;
    end else if (dec.cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = (clr_addr == AW'(CENTER)) ? CELL_INFECTED : CELL_SUSCEPTIBLE;
    end else begin
      mem_we    = s2_adv && dec.wr_en;
      mem_waddr = dec.wr_active ? addr_a2 : addr_p2;
      mem_wdata = dec.wr_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_a2 <= lattice[addr_a];
      rd_p2 <= lattice[addr_p];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      range2    <= in_range;
      above2    <= action_draw > threshold;
      addr_a2   <= addr_a;
      addr_p2   <= addr_p;
      fwd_a2    <= mem_we && (mem_waddr == addr_a);
      fwd_p2    <= mem_we && (mem_waddr == addr_p);
      fwd_cell2 <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= NW'(1);
    end else if (s2_adv) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (accept) begin
      v2 <= 1'b1;
    end else if (s2_adv) begin
      v2 <= 1'b0;
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      event_res      <= dec.evt;
      infected_count <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

endmodule

// ===== src/lsir_step.sv =====
// contact attempt decision: infection, recovery or nothing
module lsir_step (
  input  lsir_pkg::cell_t     cell_active,
  input  lsir_pkg::cell_t     cell_passive,
  input  logic                in_range,
  input  logic                draw_above,
  input  logic                count_zero,
  output lsir_pkg::decision_t dec
);
  import lsir_pkg::*;

  always_comb begin
    dec = '0;
    dec.wr_cell = CELL_SUSCEPTIBLE;
    dec.evt = EVENT_NONE;
    if (in_range && cell_active == CELL_INFECTED) begin
      if (draw_above) begin
        if (cell_passive == CELL_SUSCEPTIBLE) begin
          dec.wr_en     = 1'b1;
          dec.wr_active = 1'b0;
          dec.wr_cell   = CELL_INFECTED;
          dec.evt       = EVENT_INFECT;
          dec.cnt_inc   = 1'b1;
        end
      end else begin
        dec.wr_en     = 1'b1;
        dec.wr_active = 1'b1;
        dec.wr_cell   = CELL_RECOVERED;
        dec.evt       = EVENT_RECOVER;
        dec.cnt_dec   = !count_zero;
      end
    end
  end

endmodule

// ===== tb/tb_lattice_sir_contact_update.sv =====
// testbench for lattice_sir_contact_update: contact attempts checked against a private lattice copy
module tb_lattice_sir_contact_update;
  import lsir_pkg::*;

  localparam int SIDE = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int MAX_CYCLES = 1000000;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    event_t   evt;
    cnt_out_t cnt;
  } outcome_t;

  class sir_scoreboard;
    cell_t       grid [CELLS];
    int unsigned infected_total;
    draw_t       recovery_thr;
    event_t      last_evt;
    outcome_t    outcome_q [$];
    int          errors;
    int          beats_out;

    function new();
      for (int i = 0; i < CELLS; i++) grid[i] = CELL_SUSCEPTIBLE;
      grid[(SIDE / 2) * SIDE + SIDE / 2] = CELL_INFECTED;
      infected_total = 1;
      recovery_thr = THRESHOLD_RESET;
      last_evt = EVENT_NONE;
      errors = 0;
      beats_out = 0;
    endfunction

    // torus neighbour as a flat cell index
    function int neighbor(coord_t row, coord_t col, dir_t dir);
      int nr, nc;
      nr = row;
      nc = col;
      case (dir)
        DIR_ROW_INC: nr = (int'(row) + 1) % SIDE;
        DIR_ROW_DEC: nr = (int'(row) + SIDE - 1) % SIDE;
        DIR_COL_INC: nc = (int'(col) + 1) % SIDE;
        default:     nc = (int'(col) + SIDE - 1) % SIDE;
      endcase
      return nr * SIDE + nc;
    endfunction

    function int find_cell(cell_t want);
      int start, j;
      start = $urandom_range(0, CELLS - 1);
      for (int i = 0; i < CELLS; i++) begin
        j = (start + i) % CELLS;
        if (grid[j] == want) return j;
      end
      return -1;
    endfunction

    function void note_attempt(coord_t row, coord_t col, dir_t dir, draw_t draw);
      int active, passive;
      outcome_t o;
      o.evt = EVENT_NONE;
      if (int'(row) < SIDE && int'(col) < SIDE) begin
        active = int'(row) * SIDE + int'(col);
        passive = neighbor(row, col, dir);
        if (draw > recovery_thr) begin
          if (grid[active] == CELL_INFECTED && grid[passive] == CELL_SUSCEPTIBLE) begin
            grid[passive] = CELL_INFECTED;
            infected_total++;
            o.evt = EVENT_INFECT;
          end
        end else if (grid[active] == CELL_INFECTED) begin
          grid[active] = CELL_RECOVERED;
          if (infected_total > 0) infected_total--;
          o.evt = EVENT_RECOVER;
        end
      end
      o.cnt = cnt_out_t'(infected_total);
      last_evt = o.evt;
      outcome_q.push_back(o);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at result beat %0d: %s", beats_out, msg);
      errors++;
    endtask

    task check_result(event_t evt, cnt_out_t cnt);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        report($sformatf("beat with nothing pending, event %0d count %0d", evt, cnt));
      end else begin
        o = outcome_q.pop_front();
        if (evt !== o.evt)
          report($sformatf("event_res %0d, predicted %0d", evt, o.evt));
        if (cnt !== o.cnt)
          report($sformatf("infected_count %0d, predicted %0d", cnt, o.cnt));
      end
      beats_out++;
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     cfg_wr_en;
  draw_t    cfg_wr_data;
  logic     in_valid;
  logic     in_ready;
  coord_t   site_row;
  coord_t   site_col;
  dir_t     direction;
  draw_t    action_draw;
  logic     out_valid;
  logic     out_ready;
  event_t   event_res;
  cnt_out_t infected_count;

  bit steady;
  sir_scoreboard sb = new();

  lattice_sir_contact_update #(.SIDE(SIDE)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .site_row       (site_row),
    .site_col       (site_col),
    .direction      (direction),
    .action_draw    (action_draw),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .infected_count (infected_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * MAX_CYCLES);
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, none while steady
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(event_res, infected_count);
      if (stall > 0 && !steady) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  task automatic send_attempt(input coord_t r, input coord_t c, input dir_t d, input draw_t w);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    site_row    <= r;
    site_col    <= c;
    direction   <= d;
    action_draw <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_attempt(r, c, d, w);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.outcome_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (sb.outcome_q.size() != 0) sb.report("results still outstanding after drain");
  endtask

  task automatic write_threshold(input draw_t v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.recovery_thr = v;
  endtask

  // draw on the infecting or the recovering side of the threshold, edges now and then
  function automatic draw_t pick_draw(input bit spread);
    int thr, k;
    thr = sb.recovery_thr;
    k = $urandom_range(0, 19);
    if (k == 0) return draw_t'(thr);
    if (k == 1) return draw_t'(thr + 1);
    if (spread && thr != 16'hFFFF) return draw_t'($urandom_range(thr + 1, 16'hFFFF));
    if (!spread) return draw_t'($urandom_range(0, thr));
    return draw_t'($urandom);
  endfunction

  // keep the epidemic alive but bounded
  function automatic bit want_spread();
    int n;
    n = sb.infected_total;
    if (n < 20) return 1'b1;
    if (n < 150) return $urandom_range(0, 99) < 65;
    return $urandom_range(0, 99) < 35;
  endfunction

  task automatic run_random(input int n_items);
    int left, k, idx, steps;
    coord_t r, c;
    dir_t d;
    draw_t w;
    left = n_items;
    while (left > 0) begin
      k = $urandom_range(0, 99);
      idx = -1;
      if (k < 12) begin
        // march: infect along a straight line so fronts reach the edges and wrap
        idx = sb.find_cell(CELL_INFECTED);
        if (idx >= 0) begin
          d = dir_t'($urandom_range(0, 3));
          steps = $urandom_range(4, 70);
          r = coord_t'(idx / SIDE);
          c = coord_t'(idx % SIDE);
          while (steps > 0 && left > 0) begin
            send_attempt(r, c, d, pick_draw(1'b1));
            left--;
            steps--;
            if (sb.last_evt != EVENT_INFECT) begin
              steps = 0;
            end else begin
              idx = sb.neighbor(r, c, d);
              r = coord_t'(idx / SIDE);
              c = coord_t'(idx % SIDE);
            end
          end
        end
      end else begin
        if (k >= 32 && k < 42) idx = sb.find_cell(CELL_RECOVERED);
        else if (k >= 42) idx = sb.find_cell(CELL_INFECTED);
        d = dir_t'($urandom_range(0, 3));
        if (idx < 0) begin
          r = coord_t'($urandom);
          c = coord_t'($urandom);
          w = draw_t'($urandom);
        end else begin
          r = coord_t'(idx / SIDE);
          c = coord_t'(idx % SIDE);
          w = (k < 42) ? draw_t'($urandom) : pick_draw(want_spread());
        end
        send_attempt(r, c, d, w);
        left--;
      end
    end
  endtask

  initial begin
    int n, tail;
    steady = 1'b0;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    site_row    <= '0;
    site_col    <= '0;
    direction   <= DIR_ROW_INC;
    action_draw <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, threshold still at its reset value
    send_attempt(6'd0, 6'd0, DIR_ROW_INC, 16'd0);
    send_attempt(6'd63, 6'd63, DIR_COL_DEC, 16'hFFFF);
    send_attempt(6'd63, 6'd0, DIR_COL_DEC, 16'hFFFF);
    send_attempt(6'd0, 6'd63, DIR_ROW_DEC, 16'd0);
    send_attempt(6'd32, 6'd32, DIR_ROW_INC, 16'hFFFF);
    send_attempt(6'd32, 6'd32, DIR_ROW_DEC, THRESHOLD_RESET + 16'd1);
    send_attempt(6'd32, 6'd32, DIR_COL_INC, THRESHOLD_RESET);
    send_attempt(6'd32, 6'd32, DIR_COL_DEC, 16'hFFFF);
    send_attempt(6'd33, 6'd32, DIR_ROW_DEC, 16'hFFFF);
    send_attempt(6'd33, 6'd32, DIR_COL_INC, 16'd40000);
    send_attempt(6'd32, 6'd33, DIR_ROW_INC, 16'd0);
    send_attempt(6'd33, 6'd33, DIR_ROW_DEC, 16'd50000);
    send_attempt(6'd33, 6'd33, DIR_COL_DEC, 16'hFFFF);
    send_attempt(6'd31, 6'd32, DIR_COL_DEC, 16'd0);
    send_attempt(6'd31, 6'd32, DIR_COL_INC, 16'hFFFF);

    run_random(220);
    write_threshold(16'd0);
    run_random(300);
    write_threshold(draw_t'($urandom_range(0, 50000)));
    run_random(400);
    write_threshold(draw_t'($urandom_range(1000, 20000)));
    steady = 1'b1;
    run_random(175);
    steady = 1'b0;
    run_random(175);

    // every draw recovers: run the epidemic out, then keep going with none infected
    write_threshold(16'hFFFF);
    n = 0;
    tail = 0;
    while (n < 500 && tail < 40) begin
      if (sb.infected_total == 0) tail++;
      run_random(1);
      n++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
